>>> design/sesm_pkg.sv
`default_nettype none
package sesm_pkg;

	localparam int PATTERN_MAX_DEF = 32;
	localparam int PAT_CHARS       = 32;
	localparam int PAT_WORDS       = 4;
	localparam int CHARS_PER_WORD  = 8;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 64;
	localparam int LEN_REG_W       = 6;
	localparam int TMO_W           = 9;
	localparam int CHAR_W          = 7;

	localparam logic [TMO_W-1:0]  TIMEOUT_CAP   = 9'd300;
	localparam logic [TMO_W-1:0]  TIMEOUT_RESET = 9'd30;

	localparam logic [CHAR_W-1:0] CH_TAB   = 7'o011;
	localparam logic [CHAR_W-1:0] CH_NL    = 7'o012;
	localparam logic [CHAR_W-1:0] CH_SPACE = 7'o040;
	localparam logic [CHAR_W-1:0] CH_DEL   = 7'o177;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LEN = 3'd0,
		REG_WORD_0      = 3'd1,
		REG_WORD_1      = 3'd2,
		REG_WORD_2      = 3'd3,
		REG_WORD_3      = 3'd4,
		REG_TIMEOUT     = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_ARM  = 2'd0,
		KIND_BYTE = 2'd1,
		KIND_TICK = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE    = 2'd0,
		ST_SEARCH  = 2'd1,
		ST_MATCH   = 2'd2,
		ST_TIMEOUT = 2'd3
	} status_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] rx_byte;
	} sesm_in_t;

	typedef struct packed {
		status_t           status;
		logic              echo_valid;
		logic [CHAR_W-1:0] echo_char;
	} sesm_out_t;

	typedef struct packed {
		logic              upd;
		logic              clr;
		logic [CHAR_W-1:0] ch;
	} sesm_cell_ctl_t;

	typedef struct packed {
		logic arm;
		logic tick;
	} sesm_tmr_ctl_t;

endpackage
`default_nettype wire

>>> design/sesm_cell.sv
`default_nettype none
module sesm_cell #(
	parameter int IDX   = 0,
	parameter int LEN_W = 6
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire sesm_pkg::sesm_cell_ctl_t         ctl,
	input  wire logic [7:0]                       pat_char,
	input  wire logic [LEN_W-1:0]                 eff_len,
	input  wire logic                             prev_hit,
	output logic                                  hit_q,
	output logic                                  match_here
);
	import sesm_pkg::*;

	logic in_len;
	logic is_last;
	logic hit_next;

	// A pattern byte with bit 7 set can never equal a 7-bit character.
	assign in_len     = eff_len > LEN_W'(IDX);
	assign is_last    = eff_len == LEN_W'(IDX + 1);
	assign hit_next   = prev_hit & in_len & (pat_char == {1'b0, ctl.ch});
	assign match_here = ctl.upd & hit_next & is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.clr) begin
			hit_q <= 1'b0;
		end else if (ctl.upd) begin
			hit_q <= hit_next;
		end
	end

endmodule
`default_nettype wire

>>> design/sesm_timer.sv
`default_nettype none
module sesm_timer (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire sesm_pkg::sesm_tmr_ctl_t         ctl,
	input  wire logic [sesm_pkg::TMO_W-1:0]      timeout_q,
	output logic                                 expire
);
	import sesm_pkg::*;

	logic [TMO_W-1:0] elapsed_q;
	logic [TMO_W-1:0] elapsed_next;
	logic [TMO_W-1:0] lim;
	logic             count;

	assign lim          = (timeout_q > TIMEOUT_CAP) ? TIMEOUT_CAP : timeout_q;
	assign count        = ctl.tick & (lim != '0);
	assign elapsed_next = (elapsed_q == '1) ? elapsed_q : elapsed_q + TMO_W'(1);
	assign expire       = count & (elapsed_next >= lim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
		end else if (ctl.arm) begin
			elapsed_q <= '0;
		end else if (count) begin
			elapsed_q <= elapsed_next;
		end
	end

endmodule
`default_nettype wire

>>> design/sesm_outq.sv
`default_nettype none
module sesm_outq (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    push,
	input  wire sesm_pkg::sesm_out_t     push_data,
	output logic                         has_room,
	output logic                         result_valid,
	input  wire logic                    result_ready,
	output sesm_pkg::sesm_out_t          result_data
);
	import sesm_pkg::*;

	sesm_out_t  head_q;
	sesm_out_t  tail_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign has_room     = cnt_q != 2'd2;
	assign result_valid = cnt_q != 2'd0;
	assign result_data  = head_q;
	assign pop          = result_valid & result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (cnt_q == 2'd2) begin
				head_q <= tail_q;
				if (push) tail_q <= push_data;
			end else if (push) begin
				head_q <= push_data;
			end
		end else if (push) begin
			if (cnt_q == 2'd0) head_q <= push_data;
			else tail_q <= push_data;
		end
	end

endmodule
`default_nettype wire

>>> design/stream_expect_string_matcher.sv
`default_nettype none
// Channel    Beat holds                           Handshake
// item       kind, rx_byte (sesm_in_t)            item_valid / item_ready
// result     status, echo_valid, echo_char        result_valid / result_ready
// config     register index and 64-bit data       cfg_we (no wait, no read-back)
//
// Every accepted item yields one result beat, registered in the result queue.
// A two-entry result queue lets a new item be taken each cycle, even while
// one finished result is still waiting; item_ready drops only when both
// entries are full. The match vector and the seconds counter update in the
// cycle of acceptance, so while results are taken the rate is one item per cycle.
// arst_n clears the search state, the queue and all configuration registers
// (the timeout register comes up at 30 seconds).
module stream_expect_string_matcher #(
	parameter int PATTERN_MAX = sesm_pkg::PATTERN_MAX_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 item_valid,
	output logic                                      item_ready,
	input  wire sesm_pkg::sesm_in_t                   item_data,
	output logic                                      result_valid,
	input  wire logic                                 result_ready,
	output sesm_pkg::sesm_out_t                       result_data,
	input  wire logic                                 cfg_we,
	input  wire logic [sesm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [sesm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
	import sesm_pkg::*;

	localparam int LEN_W = $clog2(PATTERN_MAX + 1);

	// Configuration registers.
	logic [LEN_REG_W-1:0]  pattern_len_q;
	logic [CFG_DATA_W-1:0] pattern_word_q [PAT_WORDS];
	logic [TMO_W-1:0]      timeout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_len_q <= '0;
			for (int w = 0; w < PAT_WORDS; w++) pattern_word_q[w] <= '0;
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_PATTERN_LEN: pattern_len_q     <= cfg_wdata[LEN_REG_W-1:0];
				REG_WORD_0:      pattern_word_q[0] <= cfg_wdata;
				REG_WORD_1:      pattern_word_q[1] <= cfg_wdata;
				REG_WORD_2:      pattern_word_q[2] <= cfg_wdata;
				REG_WORD_3:      pattern_word_q[3] <= cfg_wdata;
				REG_TIMEOUT:     timeout_q         <= cfg_wdata[TMO_W-1:0];
				default: ;
			endcase
		end
	end

	// The effective pattern length is capped by the number of cells.
	logic [LEN_W-1:0] eff_len;

	always_comb begin
		if (int'(pattern_len_q) > PATTERN_MAX) begin
			eff_len = LEN_W'(PATTERN_MAX);
		end else begin
			eff_len = LEN_W'(pattern_len_q);
		end
	end

	// Item decode and the received-character filter. The line byte is cut to
	// seven bits; tab and newline are kept, other control codes and DEL drop.
	logic              accept;
	logic              is_arm;
	logic              is_byte;
	logic              is_tick;
	logic [CHAR_W-1:0] ch;
	logic              keep;
	logic              searching_q;
	logic              byte_upd;

	assign accept  = item_valid & item_ready;
	assign is_arm  = accept & (item_data.kind == KIND_ARM);
	assign is_byte = accept & (item_data.kind == KIND_BYTE);
	assign is_tick = accept & (item_data.kind == KIND_TICK);
	assign ch      = item_data.rx_byte[CHAR_W-1:0];
	assign keep    = ((ch >= CH_SPACE) || (ch == CH_TAB) || (ch == CH_NL)) && (ch != CH_DEL);
	assign byte_upd = is_byte & searching_q & keep;

	// Shift-and chain. Cell i holds the bit "pattern characters 0 to i end at
	// the last kept byte"; on each kept byte it takes the old bit of its left
	// neighbor (cell 0 takes a constant one) and keeps it only if the new
	// byte equals its own pattern character. Cells past the 32 configured
	// characters see a zero byte, which the filter never lets through.
	sesm_cell_ctl_t         cell_ctl;
	logic [PATTERN_MAX-1:0] hit_q;
	logic [PATTERN_MAX-1:0] match_here;
	logic                   match;
	logic                   expire;

	assign match = byte_upd & ((|match_here) | (eff_len == '0));

	assign cell_ctl.upd = byte_upd;
	assign cell_ctl.clr = is_arm | match | expire;
	assign cell_ctl.ch  = ch;

	for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
		logic [7:0] pchar;
		logic       prev_hit;

		if (i < PAT_CHARS) begin : g_char
			localparam int WORD = i / CHARS_PER_WORD;
			localparam int LANE = i % CHARS_PER_WORD;
			assign pchar = pattern_word_q[WORD][LANE*8 +: 8];
		end else begin : g_nochar
			assign pchar = 8'h00;
		end

		if (i == 0) begin : g_head
			assign prev_hit = 1'b1;
		end else begin : g_link
			assign prev_hit = hit_q[i-1];
		end

		sesm_cell #(
			.IDX   (i),
			.LEN_W (LEN_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (cell_ctl),
			.pat_char   (pchar),
			.eff_len    (eff_len),
			.prev_hit   (prev_hit),
			.hit_q      (hit_q[i]),
			.match_here (match_here[i])
		);
	end

	// Seconds counter; ticks count only while a search runs.
	sesm_tmr_ctl_t tmr_ctl;

	assign tmr_ctl.arm  = is_arm;
	assign tmr_ctl.tick = is_tick & searching_q;

	sesm_timer u_timer (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (tmr_ctl),
		.timeout_q (timeout_q),
		.expire    (expire)
	);

	// Search flag: an arm starts a search unless the pattern is empty, and a
	// match or a timeout ends it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			searching_q <= 1'b0;
		end else if (is_arm) begin
			searching_q <= eff_len != '0;
		end else if (match | expire) begin
			searching_q <= 1'b0;
		end
	end

	// Result beat for the accepted item.
	sesm_out_t res;
	status_t   run_status;

	assign run_status = searching_q ? ST_SEARCH : ST_IDLE;

	always_comb begin
		res.echo_valid = byte_upd;
		res.echo_char  = byte_upd ? ch : '0;
		case (item_data.kind)
			KIND_ARM:  res.status = (eff_len == '0) ? ST_MATCH : ST_SEARCH;
			KIND_BYTE: res.status = match ? ST_MATCH : run_status;
			KIND_TICK: res.status = expire ? ST_TIMEOUT : run_status;
			default:   res.status = run_status;
		endcase
	end

	sesm_outq u_outq (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (accept),
		.push_data    (res),
		.has_room     (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data)
	);

	// The match vector is empty whenever no search is running.
	a_idle_no_hits: assert property (@(posedge clk) disable iff (!arst_n)
		!searching_q |-> (hit_q == '0))
		else $error("prefix hits set while idle");

	// Only the cell at the pattern end may report a match.
	a_one_end: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match_here))
		else $error("more than one cell reports a match");

	// A match or a timeout leaves the block idle in the next cycle.
	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(match | expire) |=> !searching_q)
		else $error("search still running after it ended");

	// A timeout can only come from a tick taken during a search.
	a_expire_src: assert property (@(posedge clk) disable iff (!arst_n)
		expire |-> (is_tick && searching_q))
		else $error("timeout without a tick during a search");

	// An echoed character always passed the filter during a search.
	a_echo_src: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && res.echo_valid) |-> (searching_q && keep && is_byte))
		else $error("echo outside of a search");

endmodule
`default_nettype wire
